FILE: rtl/core/tbdp_pkg.sv
`default_nettype none
package tbdp_pkg;

  localparam int AddrW    = 48;
  localparam int HashFold = 16;
  localparam int HistW    = 12;
  localparam int HistMax  = 12;
  localparam int LenW     = 4;
  localparam int CtrW     = 2;
  localparam int PidxW    = 12;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 4;

  localparam logic OP_PREDICT = 1'b0;
  localparam logic OP_UPDATE  = 1'b1;

  localparam logic [CfgIdxW-1:0] REG_HISTORY_XOR_MODE = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_HISTORY_LENGTH   = 2'd1;

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_EXEC  = 3'b100
  } state_t;

  // 2-bit saturating counter step
  function automatic logic [CtrW-1:0] sat_step(input logic [CtrW-1:0] c, input logic up);
    logic [CtrW-1:0] r;
    if (up) r = (c == 2'd3) ? 2'd3 : c + 2'd1;
    else    r = (c == 2'd0) ? 2'd0 : c - 2'd1;
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/tbdp_ram.sv
`default_nettype none
module tbdp_ram #(
  parameter int Width = 2,
  parameter int Depth = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/tournament_branch_direction_predictor.sv
`default_nettype none
// channel | direction | handshake          | word
// in      | input     | in_valid/in_stall   | operation, addresses, kind flags, saved fields
// out     | output    | out_valid/out_stall | direction, next address, sub-predictions, index
// cfg     | input     | cfg_we              | cfg_index, cfg_data
//
// each word is accepted in idle, where the accept edge issues the counter reads;
// in exec the read data form the result or write the counters back
// after reset a clearing pass writes each index below 2**max(index bits) (4096 by default)
// with in_stall high; cfg writes are taken during it
// a result waits in the output register under out_stall while the next word is
// accepted; a predict word behind a full output register holds in exec
module tournament_branch_direction_predictor #(
  parameter int BIMODAL_INDEX_BITS = 12,
  parameter int META_INDEX_BITS    = 12,
  parameter int PATTERN_INDEX_BITS = 12
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // configuration
  input  wire logic                          cfg_we,
  input  wire logic [tbdp_pkg::CfgIdxW-1:0]  cfg_index,
  input  wire logic [tbdp_pkg::CfgDataW-1:0] cfg_data,
  // input channel
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic                          operation,
  input  wire logic [tbdp_pkg::AddrW-1:0]    branch_addr,
  input  wire logic [tbdp_pkg::AddrW-1:0]    branch_target,
  input  wire logic                          is_conditional,
  input  wire logic                          is_return,
  input  wire logic                          is_indirect,
  input  wire logic                          taken,
  input  wire logic                          saved_bimodal_dir,
  input  wire logic                          saved_pattern_dir,
  input  wire logic [tbdp_pkg::PidxW-1:0]    saved_pattern_index,
  // output channel
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic                               predicted_taken,
  output logic [tbdp_pkg::AddrW-1:0]         predicted_next,
  output logic                               chose_pattern,
  output logic                               bimodal_dir,
  output logic                               pattern_dir,
  output logic [tbdp_pkg::PidxW-1:0]         pattern_index
);
  import tbdp_pkg::*;

  localparam int BW = BIMODAL_INDEX_BITS;
  localparam int MW = META_INDEX_BITS;
  localparam int PW = PATTERN_INDEX_BITS;
  localparam int BMMax = (BW > MW) ? BW : MW;
  localparam int ClrW  = (BMMax > PW) ? BMMax : PW;

  // control state
  state_t            state;
  logic [ClrW-1:0]   clr_cnt;
  logic              xor_mode;
  logic [LenW-1:0]   hist_len;
  logic [HistW-1:0]  hist;

  // word held across the read cycle
  logic              it_op;
  logic [AddrW-1:0]  it_addr;
  logic [AddrW-1:0]  it_target;
  logic              it_cond;
  logic              it_train;
  logic              it_taken;
  logic              it_sbim;
  logic              it_spat;
  logic [BW-1:0]     it_bi;
  logic [MW-1:0]     it_mi;
  logic [PW-1:0]     it_pi;

  logic              in_accept;
  logic              out_free;
  logic              exec_done;
  logic              clearing;
  logic              train_in;

  logic [AddrW-1:0]  fold;
  logic [BW-1:0]     bi;
  logic [MW-1:0]     mi;
  logic [PW-1:0]     pi;
  logic [PW-1:0]     spidx;
  logic [LenW-1:0]   eff_len;
  logic [HistW-1:0]  hist_mask;
  logic [HistW-1:0]  hist_next;
  logic [AddrW-1:0]  hist_wide;
  logic [AddrW-1:0]  pat_val;

  logic [CtrW-1:0]   bim_rdata, met_rdata, pat_rdata;
  logic [CtrW-1:0]   bim_wdata, met_wdata, pat_wdata;
  logic              bim_we, met_we, pat_we;
  logic [BW-1:0]     bim_waddr;
  logic [MW-1:0]     met_waddr;
  logic [PW-1:0]     pat_waddr;
  logic [PW-1:0]     pat_raddr;
  logic [CtrW-1:0]   clr_val;
  logic              wb_en;

  state_t            state_next;

  // handshakes
  assign in_stall  = (state != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign exec_done = (it_op == OP_UPDATE) || out_free;
  assign clearing  = (state == ST_CLEAR);

  // update trains only conditional branches that are not indirect returns
  assign train_in = is_conditional && !(is_indirect && is_return);

  // folded address hash shared by bimodal and meta tables
  assign fold  = (branch_addr >> HashFold) ^ branch_addr;
  assign bi    = fold[BW-1:0];
  assign mi    = fold[MW-1:0];

  // pattern index from global history
  assign eff_len   = (hist_len > LenW'(HistMax)) ? LenW'(HistMax) : hist_len;
  assign hist_wide = AddrW'(hist);
  assign pat_val   = xor_mode ? (hist_wide ^ branch_addr)
                              : (hist_wide | (branch_addr << eff_len));
  assign pi        = pat_val[PW-1:0];
  assign spidx     = PW'(saved_pattern_index);
  assign pat_raddr = (operation == OP_UPDATE) ? spidx : pi;

  // history shift with length mask
  assign hist_mask = HistW'((13'(1) << eff_len) - 13'(1));
  assign hist_next = {hist[HistW-2:0], taken} & hist_mask;

  // write back: clearing pass or trained counters
  assign clr_val   = CtrW'(clr_cnt[0]) + CtrW'(1);
  assign wb_en     = (state == ST_EXEC) && (it_op == OP_UPDATE) && it_train;
  assign bim_we    = clearing || wb_en;
  assign pat_we    = clearing || wb_en;
  assign met_we    = clearing || (wb_en && (it_sbim != it_spat));
  assign bim_waddr = clearing ? clr_cnt[BW-1:0] : it_bi;
  assign met_waddr = clearing ? clr_cnt[MW-1:0] : it_mi;
  assign pat_waddr = clearing ? clr_cnt[PW-1:0] : it_pi;
  assign bim_wdata = clearing ? clr_val : sat_step(bim_rdata, it_taken);
  assign pat_wdata = clearing ? clr_val : sat_step(pat_rdata, it_taken);
  assign met_wdata = clearing ? clr_val : sat_step(met_rdata, it_spat == it_taken);

  tbdp_ram #(.Width(CtrW), .Depth(2 ** BW)) u_bim_ram (
    .clk   (clk),
    .we    (bim_we),
    .waddr (bim_waddr),
    .wdata (bim_wdata),
    .re    (in_accept),
    .raddr (bi),
    .rdata (bim_rdata)
  );

  tbdp_ram #(.Width(CtrW), .Depth(2 ** MW)) u_met_ram (
    .clk   (clk),
    .we    (met_we),
    .waddr (met_waddr),
    .wdata (met_wdata),
    .re    (in_accept),
    .raddr (mi),
    .rdata (met_rdata)
  );

  tbdp_ram #(.Width(CtrW), .Depth(2 ** PW)) u_pat_ram (
    .clk   (clk),
    .we    (pat_we),
    .waddr (pat_waddr),
    .wdata (pat_wdata),
    .re    (in_accept),
    .raddr (pat_raddr),
    .rdata (pat_rdata)
  );

  // sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: if (clr_cnt == {ClrW{1'b1}}) state_next = ST_IDLE;
      ST_IDLE:  if (in_accept) state_next = ST_EXEC;
      ST_EXEC:  if (exec_done) state_next = ST_IDLE;
      default:  state_next = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      clr_cnt <= '0;
    end else begin
      state <= state_next;
      if (clearing) begin
        clr_cnt <= clr_cnt + ClrW'(1);
      end
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      xor_mode <= 1'b1;
      hist_len <= LenW'(HistMax);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_HISTORY_XOR_MODE: xor_mode <= cfg_data[0];
        REG_HISTORY_LENGTH:   hist_len <= cfg_data[LenW-1:0];
        default: ;
      endcase
    end
  end

  // global history moves at the accept of a trained update
  always_ff @(posedge clk) begin
    if (rst) begin
      hist <= '0;
    end else if (in_accept && (operation == OP_UPDATE) && train_in) begin
      hist <= hist_next;
    end
  end

  // word capture
  always_ff @(posedge clk) begin
    if (in_accept) begin
      it_op     <= operation;
      it_addr   <= branch_addr;
      it_target <= branch_target;
      it_cond   <= is_conditional;
      it_train  <= train_in;
      it_taken  <= taken;
      it_sbim   <= saved_bimodal_dir;
      it_spat   <= saved_pattern_dir;
      it_bi     <= bi;
      it_mi     <= mi;
      it_pi     <= (operation == OP_UPDATE) ? spidx : pi;
    end
  end

  // output register: loaded by a predict word in exec
  logic load_out;
  logic pt;
  assign load_out = (state == ST_EXEC) && (it_op == OP_PREDICT) && out_free;
  assign pt       = met_rdata[1] ? pat_rdata[1] : bim_rdata[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      if (!it_cond) begin
        // unconditional: always taken, sub-prediction fields zero
        predicted_taken <= 1'b1;
        predicted_next  <= it_target;
        chose_pattern   <= 1'b0;
        bimodal_dir     <= 1'b0;
        pattern_dir     <= 1'b0;
        pattern_index   <= '0;
      end else begin
        predicted_taken <= pt;
        predicted_next  <= pt ? it_target : it_addr;
        chose_pattern   <= met_rdata[1];
        bimodal_dir     <= bim_rdata[1];
        pattern_dir     <= pat_rdata[1];
        pattern_index   <= PidxW'(it_pi);
      end
    end
  end

  // checks
  a_accept_to_exec: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> (state == ST_EXEC))
    else $error("accepted word did not enter exec");

  a_out_from_predict: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past((state == ST_EXEC) && (it_op == OP_PREDICT)))
    else $error("result raised without a predict word in exec");

  a_hist_on_update: assert property (@(posedge clk) disable iff (rst)
    !$stable(hist) |-> ($past(rst) || $past(in_accept && (operation == OP_UPDATE))))
    else $error("history changed without an update word");

  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    (bim_we || met_we || pat_we) |-> (state != ST_IDLE))
    else $error("counter write while idle");

endmodule
`default_nettype wire

FILE: bench/tbdp_checker.sv
module tbdp_checker (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [tbdp_pkg::CfgIdxW-1:0]  cfg_index,
  input  wire logic [tbdp_pkg::CfgDataW-1:0] cfg_data,
  input  wire logic                          in_valid,
  input  wire logic                          in_stall,
  input  wire logic                          operation,
  input  wire logic [tbdp_pkg::AddrW-1:0]    branch_addr,
  input  wire logic [tbdp_pkg::AddrW-1:0]    branch_target,
  input  wire logic                          is_conditional,
  input  wire logic                          is_return,
  input  wire logic                          is_indirect,
  input  wire logic                          taken,
  input  wire logic                          saved_bimodal_dir,
  input  wire logic                          saved_pattern_dir,
  input  wire logic [tbdp_pkg::PidxW-1:0]    saved_pattern_index,
  input  wire logic                          out_valid,
  input  wire logic                          out_stall,
  input  wire logic                          predicted_taken,
  input  wire logic [tbdp_pkg::AddrW-1:0]    predicted_next,
  input  wire logic                          chose_pattern,
  input  wire logic                          bimodal_dir,
  input  wire logic                          pattern_dir,
  input  wire logic [tbdp_pkg::PidxW-1:0]    pattern_index,
  output int                                 fail_count,
  output int                                 pending_words
);
  import tbdp_pkg::*;

  localparam int IdxBits = 12;
  localparam int Rows    = 1 << IdxBits;

  typedef struct packed {
    logic             dir;
    logic [AddrW-1:0] next;
    logic             chose;
    logic             bim;
    logic             pat;
    logic [PidxW-1:0] idx;
  } direction_result_t;

  logic [CtrW-1:0]  bim_ctr  [Rows];
  logic [CtrW-1:0]  meta_ctr [Rows];
  logic [CtrW-1:0]  pat_ctr  [Rows];
  logic [HistW-1:0] ghist;
  logic             xor_mode;
  logic [LenW-1:0]  hist_len;

  direction_result_t expected_dirs[$];
  int errs = 0;

  initial begin
    fail_count    = 0;
    pending_words = 0;
  end

  function automatic logic [IdxBits-1:0] addr_fold(input logic [AddrW-1:0] a);
    logic [AddrW-1:0] f;
    f = (a >> HashFold) ^ a;
    return f[IdxBits-1:0];
  endfunction

  function automatic logic [LenW-1:0] used_len();
    return (hist_len > LenW'(HistMax)) ? LenW'(HistMax) : hist_len;
  endfunction

  function automatic logic [PidxW-1:0] pattern_slot(input logic [AddrW-1:0] a);
    logic [PidxW-1:0] lo;
    lo = a[PidxW-1:0];
    if (xor_mode) return ghist ^ lo;
    return ghist | PidxW'(lo << used_len());
  endfunction

  function automatic logic [CtrW-1:0] nudge(input logic [CtrW-1:0] c, input logic up);
    if (up) return (c == '1) ? c : c + 1'b1;
    return (c == '0) ? c : c - 1'b1;
  endfunction

  task automatic reset_tables();
    for (int i = 0; i < Rows; i++) begin
      bim_ctr[i]  = CtrW'((i & 1) + 1);
      meta_ctr[i] = CtrW'((i & 1) + 1);
      pat_ctr[i]  = CtrW'((i & 1) + 1);
    end
    ghist    = '0;
    xor_mode = 1'b1;
    hist_len = LenW'(HistMax);
  endtask

  function automatic direction_result_t predict_word();
    direction_result_t r;
    logic [PidxW-1:0] pi;
    r = '0;
    if (!is_conditional) begin
      r.dir  = 1'b1;
      r.next = branch_target;
      return r;
    end
    pi      = pattern_slot(branch_addr);
    r.bim   = bim_ctr[addr_fold(branch_addr)][1];
    r.pat   = pat_ctr[pi][1];
    r.chose = meta_ctr[addr_fold(branch_addr)][1];
    r.dir   = r.chose ? r.pat : r.bim;
    r.next  = r.dir ? branch_target : branch_addr;
    r.idx   = pi;
    return r;
  endfunction

  task automatic train_word();
    logic [HistW:0]     keep;
    logic [HistW:0]     grown;
    logic [IdxBits-1:0] row;
    if (is_indirect && is_return) return;
    if (!is_conditional) return;
    keep  = ((HistW+1)'(1) << used_len()) - 1'b1;
    grown = {ghist, taken} & keep;
    ghist = grown[HistW-1:0];
    row   = addr_fold(branch_addr);
    bim_ctr[row] = nudge(bim_ctr[row], taken);
    pat_ctr[saved_pattern_index] = nudge(pat_ctr[saved_pattern_index], taken);
    if (saved_bimodal_dir != saved_pattern_dir)
      meta_ctr[row] = nudge(meta_ctr[row], saved_pattern_dir == taken);
  endtask

  task automatic compare_field(input string what, input logic [AddrW-1:0] want, got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %h, got %h", $time, what, want, got);
      errs++;
    end
  endtask

  task automatic check_result();
    direction_result_t want;
    if (expected_dirs.size() == 0) begin
      $display("%0t: result word with none pending: expected nothing, got next %h",
               $time, predicted_next);
      errs++;
      return;
    end
    want = expected_dirs.pop_front();
    compare_field("predicted_taken", want.dir, predicted_taken);
    compare_field("predicted_next", want.next, predicted_next);
    compare_field("chose_pattern", want.chose, chose_pattern);
    compare_field("bimodal_dir", want.bim, bimodal_dir);
    compare_field("pattern_dir", want.pat, pattern_dir);
    compare_field("pattern_index", want.idx, pattern_index);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      reset_tables();
      expected_dirs.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_HISTORY_XOR_MODE: xor_mode = cfg_data[0];
          REG_HISTORY_LENGTH:   hist_len = cfg_data[LenW-1:0];
          default: ;
        endcase
      end
      // an output word always belongs to an earlier input word
      if (out_valid && !out_stall) check_result();
      if (in_valid && !in_stall) begin
        if (operation == OP_PREDICT) expected_dirs.push_back(predict_word());
        else train_word();
      end
    end
    fail_count    <= errs;
    pending_words <= expected_dirs.size();
  end

endmodule

FILE: bench/tb_tournament_branch_direction_predictor.sv
module tb_tournament_branch_direction_predictor;
  import tbdp_pkg::*;

  // pool of trained branch sites, half of them aliasing in the address hash
  localparam int POOL        = 24;
  localparam int QUIET_LIMIT = 20000;
  localparam int SETTLE      = 8;
  localparam int PHASES      = 8;

  typedef struct {
    logic             op;
    logic [AddrW-1:0] addr;
    logic [AddrW-1:0] target;
    logic             cond;
    logic             ret;
    logic             ind;
    logic             tkn;
    logic             sbim;
    logic             spat;
    logic [PidxW-1:0] spidx;
  } branch_word_t;

  // a predict word in flight, and what came back for it
  typedef struct {
    logic cond;
    int   site;
  } issued_t;

  typedef struct {
    int               site;
    logic             bdir;
    logic             pdir;
    logic [PidxW-1:0] pidx;
  } guess_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_data;
  logic in_valid;
  logic in_stall;
  logic operation;
  logic [AddrW-1:0] branch_addr;
  logic [AddrW-1:0] branch_target;
  logic is_conditional;
  logic is_return;
  logic is_indirect;
  logic taken;
  logic saved_bimodal_dir;
  logic saved_pattern_dir;
  logic [PidxW-1:0] saved_pattern_index;
  logic out_valid;
  logic out_stall = 1'b0;
  logic predicted_taken;
  logic [AddrW-1:0] predicted_next;
  logic chose_pattern;
  logic bimodal_dir;
  logic pattern_dir;
  logic [PidxW-1:0] pattern_index;

  int fail_count;
  int pending_words;

  int idle_pct  = 0;
  int stall_pct = 0;
  int quiet     = 0;
  int n_predict = 0;
  int n_update  = 0;
  int n_results = 0;

  logic [AddrW-1:0] site_addr   [POOL];
  logic [AddrW-1:0] site_target [POOL];
  logic             site_toggle [POOL];

  issued_t issued_q[$];
  guess_t  guesses[$];
  issued_t seen;

  // settings per phase: xor data, length data, sender idle %, receiver stall %
  int ph_xor   [PHASES] = '{1, 0, 14, 1, 15, 0, 1, 0};
  int ph_len   [PHASES] = '{12, 12, 1, 0, 15, 5, 13, 3};
  int ph_idle  [PHASES] = '{0, 60, 0, 28, 0, 28, 60, 0};
  int ph_stall [PHASES] = '{0, 0, 60, 28, 0, 28, 0, 60};
  int ph_items [PHASES] = '{110, 110, 110, 110, 110, 110, 110, 110};

  always #1 clk = ~clk;

  tournament_branch_direction_predictor uut (
    .clk                 (clk),
    .rst                 (rst),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .operation           (operation),
    .branch_addr         (branch_addr),
    .branch_target       (branch_target),
    .is_conditional      (is_conditional),
    .is_return           (is_return),
    .is_indirect         (is_indirect),
    .taken               (taken),
    .saved_bimodal_dir   (saved_bimodal_dir),
    .saved_pattern_dir   (saved_pattern_dir),
    .saved_pattern_index (saved_pattern_index),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .predicted_taken     (predicted_taken),
    .predicted_next      (predicted_next),
    .chose_pattern       (chose_pattern),
    .bimodal_dir         (bimodal_dir),
    .pattern_dir         (pattern_dir),
    .pattern_index       (pattern_index)
  );

  tbdp_checker chk (
    .clk                 (clk),
    .rst                 (rst),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .operation           (operation),
    .branch_addr         (branch_addr),
    .branch_target       (branch_target),
    .is_conditional      (is_conditional),
    .is_return           (is_return),
    .is_indirect         (is_indirect),
    .taken               (taken),
    .saved_bimodal_dir   (saved_bimodal_dir),
    .saved_pattern_dir   (saved_pattern_dir),
    .saved_pattern_index (saved_pattern_index),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .predicted_taken     (predicted_taken),
    .predicted_next      (predicted_next),
    .chose_pattern       (chose_pattern),
    .bimodal_dir         (bimodal_dir),
    .pattern_dir         (pattern_dir),
    .pattern_index       (pattern_index),
    .fail_count          (fail_count),
    .pending_words       (pending_words)
  );

  // receiver back-pressure, redrawn every cycle
  always @(posedge clk) begin
    out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
  end

  // pair each result word with its predict word; conditional ones from the
  // pool come back later as training words carrying the saved fields
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      n_results++;
      if (issued_q.size() != 0) begin
        seen = issued_q.pop_front();
        if (seen.cond && seen.site >= 0)
          guesses.push_back('{seen.site, bimodal_dir, pattern_dir, pattern_index});
      end
    end
  end

  // watchdog: cycles in a row with no word moving on either channel;
  // covers the clearing pass after reset with plenty of margin
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("%0t: no word moved for %0d cycles", $time, QUIET_LIMIT);
      $display("FAIL");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  function automatic logic [AddrW-1:0] any_addr();
    return {16'($urandom), 32'($urandom)};
  endfunction

  function automatic branch_word_t mk(input logic op, input logic [AddrW-1:0] addr, tgt,
                                      input logic cond, ret, ind, tkn, sbim, spat,
                                      input logic [PidxW-1:0] spidx);
    mk = '{op, addr, tgt, cond, ret, ind, tkn, sbim, spat, spidx};
  endfunction

  // resolved direction of a pool site: always, never, alternating or random
  function automatic logic site_outcome(input int site);
    case (site % 4)
      0: return 1'b1;
      1: return 1'b0;
      2: begin
        site_toggle[site] = ~site_toggle[site];
        return site_toggle[site];
      end
      default: return 1'($urandom);
    endcase
  endfunction

  // drive one word and hold it until the block takes it
  task automatic send(input branch_word_t w, input int site);
    if (idle_pct != 0) begin
      while ($urandom_range(99) < idle_pct) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid            <= 1'b1;
    operation           <= w.op;
    branch_addr         <= w.addr;
    branch_target       <= w.target;
    is_conditional      <= w.cond;
    is_return           <= w.ret;
    is_indirect         <= w.ind;
    taken               <= w.tkn;
    saved_bimodal_dir   <= w.sbim;
    saved_pattern_dir   <= w.spat;
    saved_pattern_index <= w.spidx;
    do @(posedge clk); while (in_stall);
    if (w.op == OP_PREDICT) begin
      issued_q.push_back('{w.cond, site});
      n_predict++;
    end else begin
      n_update++;
    end
  endtask

  // one random word: mostly predict/train pairs on pool sites, some noise
  task automatic send_random();
    branch_word_t w;
    guess_t g;
    int r;
    int s;
    r = $urandom_range(99);
    if (r < 42) begin
      s = $urandom_range(POOL - 1);
      w = mk(OP_PREDICT, site_addr[s], site_target[s], 1'b1, 1'b0, 1'b0,
             1'($urandom), 1'($urandom), 1'($urandom), PidxW'($urandom));
      send(w, s);
    end else if (r < 85) begin
      if (guesses.size() != 0) begin
        g = guesses.pop_front();
        w = mk(OP_UPDATE, site_addr[g.site], site_target[g.site], 1'b1, 1'b0, 1'b0,
               site_outcome(g.site), g.bdir, g.pdir, g.pidx);
      end else begin
        s = $urandom_range(POOL - 1);
        w = mk(OP_UPDATE, site_addr[s], site_target[s], 1'b1, 1'b0, 1'b0,
               site_outcome(s), 1'($urandom), 1'($urandom), PidxW'($urandom));
      end
      send(w, -1);
    end else begin
      w = mk(1'($urandom), any_addr(), any_addr(), 1'($urandom), 1'($urandom),
             1'($urandom), 1'($urandom), 1'($urandom), 1'($urandom), PidxW'($urandom));
      send(w, -1);
    end
  endtask

  // drop valid, wait for every result word, then let trailing training words land
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_words != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  // one write cycle; the task returns with cfg_we low again
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input int value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CfgDataW'(value);
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    logic [AddrW-1:0] hot;
    logic [AddrW-1:0] d;
    rst                 = 1'b1;
    cfg_we              = 1'b0;
    cfg_index           = '0;
    cfg_data            = '0;
    in_valid            = 1'b0;
    operation           = OP_PREDICT;
    branch_addr         = '0;
    branch_target       = '0;
    is_conditional      = 1'b0;
    is_return           = 1'b0;
    is_indirect         = 1'b0;
    taken               = 1'b0;
    saved_bimodal_dir   = 1'b0;
    saved_pattern_dir   = 1'b0;
    saved_pattern_index = '0;

    // odd sites alias their even neighbor in the bimodal/meta hash
    for (int i = 0; i < POOL; i += 2) begin
      site_addr[i]     = any_addr();
      d                = AddrW'($urandom_range(1, 4095));
      site_addr[i+1]   = site_addr[i] ^ (d << HashFold) ^ d;
      site_target[i]   = any_addr();
      site_target[i+1] = any_addr();
    end
    for (int i = 0; i < POOL; i++) site_toggle[i] = 1'b0;

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed words under the reset settings
    hot = 48'h1234_5678_9abc;
    send(mk(OP_PREDICT, '0, '1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, '0), -1);
    send(mk(OP_PREDICT, '1, '0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, '0), -1);
    // unconditional predicts, the return flag has no effect
    send(mk(OP_PREDICT, hot, '1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, '0), -1);
    send(mk(OP_PREDICT, '1, hot, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, '1), -1);
    // training with disagreeing sub-predictions moves the chooser
    send(mk(OP_UPDATE, '1, '0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1, '1), -1);
    send(mk(OP_UPDATE, '0, '1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, '0), -1);
    // indirect return and unconditional updates change nothing
    send(mk(OP_UPDATE, hot, '0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 12'hfff), -1);
    send(mk(OP_UPDATE, hot, '0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 12'h5a5), -1);
    // a plain return or a plain indirect still trains
    send(mk(OP_UPDATE, hot, '1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 12'h4d2), -1);
    send(mk(OP_UPDATE, hot, '1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 12'h0ff), -1);
    send(mk(OP_PREDICT, '1, '0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, '0), -1);
    send(mk(OP_PREDICT, '0, '1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, '0), -1);
    // drive one site into both saturation ends
    repeat (4) send(mk(OP_UPDATE, hot, '1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 12'h321), -1);
    send(mk(OP_PREDICT, hot, '1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, '0), -1);
    repeat (5) send(mk(OP_UPDATE, hot, '1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 12'h321), -1);
    send(mk(OP_PREDICT, hot, '1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, '0), -1);

    // random phases, each under its own history mode and length
    for (int p = 0; p < PHASES; p++) begin
      drain();
      write_reg(REG_HISTORY_XOR_MODE, ph_xor[p]);
      write_reg(REG_HISTORY_LENGTH, ph_len[p]);
      idle_pct  = ph_idle[p];
      stall_pct = ph_stall[p];
      repeat (ph_items[p]) send_random();
    end

    drain();
    $display("covered %0d predict and %0d training words, %0d results, over %0d settings",
             n_predict, n_update, n_results, PHASES);
    $display("history lengths 0 to 15 in both index modes, with idle and stall mixes");
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
